// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop at every rising edge of clk, skip while rst_n is low.
`define VSL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vsl assertion failed");
// Check prop at every rising edge of clk, reset included.
`define VSL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("vsl assertion failed");
`else
`define VSL_ASSERT(label, clk, rst_n, prop)
`define VSL_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- rtl/vsl_pkg.sv -----
// ---------------------------------------------------------------------------
// vsl_pkg
// Types, codes and helpers for the velocity slew limiter.
// ---------------------------------------------------------------------------
`default_nettype none

package vsl_pkg;

  localparam int unsigned Q24_W  = 24;
  localparam int unsigned STICK_W = 18;
  localparam int unsigned REG_W  = 23;
  localparam int unsigned DB_W   = 17;
  localparam int unsigned IDX_W  = 3;

  typedef logic signed [Q24_W-1:0]   q24_t;
  typedef logic signed [STICK_W-1:0] stick_t;
  typedef logic [REG_W-1:0]          reg23_t;
  typedef logic [DB_W-1:0]           db_t;

  typedef enum logic [1:0] {
    OP_JOY  = 2'd0,
    OP_CMD  = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    IDX_SPEED_GAIN = 3'd0,
    IDX_TURN_GAIN  = 3'd1,
    IDX_SPEED_STEP = 3'd2,
    IDX_TURN_STEP  = 3'd3,
    IDX_SPEED_SNAP = 3'd4,
    IDX_TURN_SNAP  = 3'd5,
    IDX_DEADBAND   = 3'd6
  } cfg_idx_t;

  localparam reg23_t RST_SPEED_GAIN = 23'd13107;
  localparam reg23_t RST_TURN_GAIN  = 23'd65536;
  localparam reg23_t RST_SPEED_STEP = 23'd328;
  localparam reg23_t RST_TURN_STEP  = 23'd39322;
  localparam reg23_t RST_SPEED_SNAP = 23'd3932;
  localparam reg23_t RST_TURN_SNAP  = 23'd19661;
  localparam db_t    RST_DEADBAND   = 17'd6554;

  typedef struct packed {
    reg23_t speed_gain;
    reg23_t turn_gain;
    reg23_t speed_step;
    reg23_t turn_step;
    reg23_t speed_snap;
    reg23_t turn_snap;
    db_t    deadband;
  } cfg_t;

  localparam q24_t Q24_MAX = 24'sh7FFFFF;
  localparam q24_t Q24_MIN = 24'sh800000;

  // Clamp a 27-bit signed value to the Q8.16 range.
  function automatic q24_t sat_q24(input logic signed [26:0] v);
    logic ovf_hi;
    logic ovf_lo;
    ovf_hi = !v[26] && (v[25:23] != 3'b000);
    ovf_lo = v[26] && (v[25:23] != 3'b111);
    if (ovf_hi) begin
      return Q24_MAX;
    end else if (ovf_lo) begin
      return Q24_MIN;
    end
    return q24_t'(v[23:0]);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/vsl_in_if.sv -----
// ---------------------------------------------------------------------------
// vsl_in_if
// Input item channel: item kind, stick axes and direct targets.
// ---------------------------------------------------------------------------
`default_nettype none

interface vsl_in_if;
  import vsl_pkg::*;
  logic         valid;
  logic         ready;
  logic [1:0]   op;
  stick_t       stick_side;
  stick_t       stick_fore;
  q24_t         cmd_linear;
  q24_t         cmd_angular;

  modport source (output valid, op, stick_side, stick_fore, cmd_linear, cmd_angular,
                  input ready);
  modport sink   (input valid, op, stick_side, stick_fore, cmd_linear, cmd_angular,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/vsl_out_if.sv -----
// ---------------------------------------------------------------------------
// vsl_out_if
// Result item channel: drive values and snap flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface vsl_out_if;
  import vsl_pkg::*;
  logic valid;
  logic ready;
  q24_t drive_speed;
  q24_t drive_turn;
  logic snapped;

  modport source (output valid, drive_speed, drive_turn, snapped, input ready);
  modport sink   (input valid, drive_speed, drive_turn, snapped, output ready);
endinterface

`default_nettype wire

// ----- rtl/vsl_cfg_if.sv -----
// ---------------------------------------------------------------------------
// vsl_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface vsl_cfg_if;
  import vsl_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  reg23_t           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/vsl_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// vsl_cfg_regs
// Configuration register file, one write per accepted item.
// ---------------------------------------------------------------------------
`default_nettype none

module vsl_cfg_regs
  import vsl_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  vsl_cfg_if.sink     cfg_ch,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        IDX_SPEED_GAIN: cfg_nxt.speed_gain = cfg_ch.data;
        IDX_TURN_GAIN:  cfg_nxt.turn_gain  = cfg_ch.data;
        IDX_SPEED_STEP: cfg_nxt.speed_step = cfg_ch.data;
        IDX_TURN_STEP:  cfg_nxt.turn_step  = cfg_ch.data;
        IDX_SPEED_SNAP: cfg_nxt.speed_snap = cfg_ch.data;
        IDX_TURN_SNAP:  cfg_nxt.turn_snap  = cfg_ch.data;
        IDX_DEADBAND:   cfg_nxt.deadband   = cfg_ch.data[DB_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_gain <= RST_SPEED_GAIN;
      cfg_r.turn_gain  <= RST_TURN_GAIN;
      cfg_r.speed_step <= RST_SPEED_STEP;
      cfg_r.turn_step  <= RST_TURN_STEP;
      cfg_r.speed_snap <= RST_SPEED_SNAP;
      cfg_r.turn_snap  <= RST_TURN_SNAP;
      cfg_r.deadband   <= RST_DEADBAND;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/vsl_target.sv -----
// ---------------------------------------------------------------------------
// vsl_target
// Target update: stick scaling with deadband, direct command, or hold.
// ---------------------------------------------------------------------------
`default_nettype none

module vsl_target
  import vsl_pkg::*;
(
  input  wire logic [1:0] op,
  input  wire stick_t     stick_side,
  input  wire stick_t     stick_fore,
  input  wire q24_t       cmd_linear,
  input  wire q24_t       cmd_angular,
  input  wire q24_t       tgt_speed,
  input  wire q24_t       tgt_turn,
  input  wire cfg_t       cfg,
  output q24_t            tgt_speed_nxt,
  output q24_t            tgt_turn_nxt
);

  logic [STICK_W-1:0]  side_mag;
  logic [STICK_W-1:0]  fore_mag;
  logic                idle;
  logic signed [41:0]  prod_speed;
  logic signed [41:0]  prod_turn;
  logic signed [41:0]  adj_speed;
  logic signed [41:0]  adj_turn;
  logic signed [25:0]  q_speed;
  logic signed [25:0]  q_turn;
  logic signed [25:0]  q_turn_dir;
  q24_t                joy_speed;
  q24_t                joy_turn;

  // Magnitude as unsigned; the most negative value maps to its true size.
  assign side_mag = stick_side[STICK_W-1] ? (-stick_side) : stick_side;
  assign fore_mag = stick_fore[STICK_W-1] ? (-stick_fore) : stick_fore;
  assign idle     = (fore_mag <= {1'b0, cfg.deadband}) && (side_mag <= {1'b0, cfg.deadband});

  assign prod_speed = 42'(stick_fore) * $signed({1'b0, cfg.speed_gain});
  assign prod_turn  = 42'(stick_side) * $signed({1'b0, cfg.turn_gain});

  // Truncate toward zero: bias negative products before the shift.
  assign adj_speed = prod_speed + (prod_speed[41] ? 42'sd65535 : 42'sd0);
  assign adj_turn  = prod_turn  + (prod_turn[41]  ? 42'sd65535 : 42'sd0);
  assign q_speed   = adj_speed[41:16];
  assign q_turn    = adj_turn[41:16];

  assign q_turn_dir = stick_fore[STICK_W-1] ? (-q_turn) : q_turn;
  assign joy_speed  = sat_q24({q_speed[25], q_speed});
  assign joy_turn   = sat_q24({q_turn_dir[25], q_turn_dir});

  always_comb begin
    unique case (op)
      OP_JOY: begin
        tgt_speed_nxt = idle ? '0 : joy_speed;
        tgt_turn_nxt  = idle ? '0 : joy_turn;
      end
      OP_CMD: begin
        tgt_speed_nxt = cmd_linear;
        tgt_turn_nxt  = cmd_angular;
      end
      default: begin
        tgt_speed_nxt = tgt_speed;
        tgt_turn_nxt  = tgt_turn;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/vsl_slew.sv -----
// ---------------------------------------------------------------------------
// vsl_slew
// Drive update: snap to targets when both are close, else step each channel.
// ---------------------------------------------------------------------------
`default_nettype none

module vsl_slew
  import vsl_pkg::*;
(
  input  wire q24_t  tgt_speed,
  input  wire q24_t  tgt_turn,
  input  wire q24_t  cur_speed,
  input  wire q24_t  cur_turn,
  input  wire cfg_t  cfg,
  output q24_t       cur_speed_nxt,
  output q24_t       cur_turn_nxt,
  output logic       snap
);

  logic signed [24:0] diff_speed;
  logic signed [24:0] diff_turn;
  logic [24:0]        mag_speed;
  logic [24:0]        mag_turn;
  logic signed [26:0] up_speed;
  logic signed [26:0] dn_speed;
  logic signed [26:0] up_turn;
  logic signed [26:0] dn_turn;
  q24_t               step_speed;
  q24_t               step_turn;

  assign diff_speed = 25'(tgt_speed) - 25'(cur_speed);
  assign diff_turn  = 25'(tgt_turn)  - 25'(cur_turn);
  assign mag_speed  = diff_speed[24] ? (-diff_speed) : diff_speed;
  assign mag_turn   = diff_turn[24]  ? (-diff_turn)  : diff_turn;

  assign snap = (mag_speed <= {2'b00, cfg.speed_snap}) &&
                (mag_turn  <= {2'b00, cfg.turn_snap});

  assign up_speed = 27'(cur_speed) + $signed({4'b0000, cfg.speed_step});
  assign dn_speed = 27'(cur_speed) - $signed({4'b0000, cfg.speed_step});
  assign up_turn  = 27'(cur_turn)  + $signed({4'b0000, cfg.turn_step});
  assign dn_turn  = 27'(cur_turn)  - $signed({4'b0000, cfg.turn_step});

  // Step toward the target; hold on zero difference.
  always_comb begin
    if (diff_speed > 0) begin
      step_speed = sat_q24(up_speed);
    end else if (diff_speed < 0) begin
      step_speed = sat_q24(dn_speed);
    end else begin
      step_speed = cur_speed;
    end
    if (diff_turn > 0) begin
      step_turn = sat_q24(up_turn);
    end else if (diff_turn < 0) begin
      step_turn = sat_q24(dn_turn);
    end else begin
      step_turn = cur_turn;
    end
  end

  assign cur_speed_nxt = snap ? tgt_speed : step_speed;
  assign cur_turn_nxt  = snap ? tgt_turn  : step_turn;

endmodule

`default_nettype wire

// ----- rtl/velocity_slew_limiter_unit.sv -----
// ---------------------------------------------------------------------------
// velocity_slew_limiter_unit
// Two-channel Q8.16 speed/turn ramp for a mobile base, one result per item.
// ---------------------------------------------------------------------------
//
//   port     dir  role
//   in_ch    in   item: op, stick_side, stick_fore, cmd_linear, cmd_angular
//   out_ch   out  result: drive_speed, drive_turn, snapped
//   cfg_ch   in   register write: index, data (always ready)
//
// An item is captured in the input register, computed from there and lands
// in the result register once that is free or draining; one item per cycle
// is sustained while out_ch is not stalled. The gain multiply, truncation,
// target select, difference and step adders form the single combinational
// stage between the registers. Targets and drive values update when the item
// moves into the result register, so the next item sees them without a gap.
// Synchronous active-low reset clears state, valids and configuration registers to defaults.
// A stalled result holds the input register; in_ch.ready drops only then.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module velocity_slew_limiter_unit
  import vsl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  vsl_in_if.sink    in_ch,
  vsl_out_if.source out_ch,
  vsl_cfg_if.sink   cfg_ch
);

  cfg_t cfg;

  // Input register
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [1:0]  s1_op_r;
  stick_t      s1_side_r;
  stick_t      s1_fore_r;
  q24_t        s1_lin_r;
  q24_t        s1_ang_r;

  // Block state
  q24_t tgt_speed_r;
  q24_t tgt_turn_r;
  q24_t cur_speed_r;
  q24_t cur_turn_r;

  q24_t tgt_speed_nxt;
  q24_t tgt_turn_nxt;
  q24_t cur_speed_nxt;
  q24_t cur_turn_nxt;
  logic snap;

  // Result register
  logic out_valid_r;
  logic out_valid_nxt;
  q24_t out_speed_r;
  q24_t out_turn_r;
  logic out_snap_r;

  logic s1_adv;
  logic in_take;

  vsl_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  vsl_target u_target (
    .op            (s1_op_r),
    .stick_side    (s1_side_r),
    .stick_fore    (s1_fore_r),
    .cmd_linear    (s1_lin_r),
    .cmd_angular   (s1_ang_r),
    .tgt_speed     (tgt_speed_r),
    .tgt_turn      (tgt_turn_r),
    .cfg           (cfg),
    .tgt_speed_nxt (tgt_speed_nxt),
    .tgt_turn_nxt  (tgt_turn_nxt)
  );

  vsl_slew u_slew (
    .tgt_speed     (tgt_speed_nxt),
    .tgt_turn      (tgt_turn_nxt),
    .cur_speed     (cur_speed_r),
    .cur_turn      (cur_turn_r),
    .cfg           (cfg),
    .cur_speed_nxt (cur_speed_nxt),
    .cur_turn_nxt  (cur_turn_nxt),
    .snap          (snap)
  );

  // Advance the computed item when the result register is free or draining.
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_take      = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tgt_speed_r <= '0;
      tgt_turn_r  <= '0;
      cur_speed_r <= '0;
      cur_turn_r  <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        tgt_speed_r <= tgt_speed_nxt;
        tgt_turn_r  <= tgt_turn_nxt;
        cur_speed_r <= cur_speed_nxt;
        cur_turn_r  <= cur_turn_nxt;
      end
    end
  end

  // Payload registers: load on take / advance, no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_ch.op;
      s1_side_r <= in_ch.stick_side;
      s1_fore_r <= in_ch.stick_fore;
      s1_lin_r  <= in_ch.cmd_linear;
      s1_ang_r  <= in_ch.cmd_angular;
    end
    if (s1_adv) begin
      out_speed_r <= cur_speed_nxt;
      out_turn_r  <= cur_turn_nxt;
      out_snap_r  <= snap;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_speed = out_speed_r;
  assign out_ch.drive_turn  = out_turn_r;
  assign out_ch.snapped     = out_snap_r;

  // A pending result always mirrors the drive state it was made from.
  `VSL_ASSERT(a_out_matches_state, clk, rst_n, out_valid_r |-> (out_speed_r == cur_speed_r && out_turn_r == cur_turn_r))
  // A snapped result leaves the drive values sitting on the targets.
  `VSL_ASSERT(a_snap_on_target, clk, rst_n, (out_valid_r && out_snap_r) |-> (cur_speed_r == tgt_speed_r && cur_turn_r == tgt_turn_r))
  // Drive state changes only when an item advances.
  `VSL_ASSERT(a_state_hold, clk, rst_n, (rst_n && !s1_adv) |=> ($stable(cur_speed_r) && $stable(cur_turn_r)))
  // Backpressure on the input only when both registers are full and stalled.
  `VSL_ASSERT_ALWAYS(a_ready_cause, clk, !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))

endmodule

`default_nettype wire
